// ===== sv/dtew_pkg.sv =====
// Shared types, constants and tables for the date to epoch days/weekday block.
// No dependencies.
package dtew_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DAYS_W  = 22;
  localparam int WD_W    = 3;
  localparam int ACC_W   = 24;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR   = YEAR_W'(1970);
  localparam logic [1:0]        EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]        EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]        EPOCH_MOD400 = 9'd370;
  // weekday = (count + 2) mod 7 with count = biased sum
  localparam logic [WD_W-1:0]   WD_INIT      = 3'd2;
  localparam logic [DAYS_W-1:0] DAYS_MAX     = {DAYS_W{1'b1}};

  localparam logic [8:0] MONTH_START [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd427
  };

  localparam logic [2:0] MONTH_START_MOD7 [16] = '{
    3'd0, 3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6,
    3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd0
  };

  localparam logic [2:0] DAY_MOD7 [32] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1,
    3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2,
    3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd3
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEARS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic years_done;
  } dp_status_t;

endpackage

// ===== sv/dtew_datapath.sv =====
// Datapath: year walk with running mod-4/100/400 counters, day and weekday sums.
// Depends on dtew_pkg.
module dtew_datapath import dtew_pkg::*; (
  input  logic                 clk,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [DAY_W-1:0]     day_of_month,
  input  logic [MONTH_W-1:0]   month_number,
  input  logic [YEAR_W-1:0]    year_number,
  output logic [DAYS_W-1:0]    epoch_days,
  output logic [WD_W-1:0]      weekday
);

  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [YEAR_W-1:0]  yr;
  logic [1:0]         mod4;
  logic [6:0]         mod100;
  logic [8:0]         mod400;
  logic [ACC_W-1:0]   acc;
  logic [WD_W-1:0]    wd;
  logic               accum;

  logic               leap;
  logic [ACC_W-1:0]   biased;
  logic [4:0]         wd_sum;
  logic [WD_W-1:0]    wd_final;
  logic [DAYS_W-1:0]  days_final;
  logic [WD_W:0]      wd_inc;
  logic [WD_W-1:0]    wd_step;

  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign status.years_done = (yr == year_r);

  always_comb begin
    wd_inc  = {1'b0, wd} + (leap ? 4'd2 : 4'd1);
    wd_step = (wd_inc >= 4'd7) ? WD_W'(wd_inc - 4'd7) : WD_W'(wd_inc);
  end

  always_comb begin
    biased = acc + ACC_W'(MONTH_START[month_r])
           + ACC_W'((month_r >= 4'd3) && leap) + ACC_W'(day_r);
    wd_sum = 5'(wd) + 5'(MONTH_START_MOD7[month_r])
           + 5'((month_r >= 4'd3) && leap) + 5'(DAY_MOD7[day_r]);
    if (wd_sum >= 5'd14) begin
      wd_final = WD_W'(wd_sum - 5'd14);
    end else if (wd_sum >= 5'd7) begin
      wd_final = WD_W'(wd_sum - 5'd7);
    end else begin
      wd_final = WD_W'(wd_sum);
    end
    if (biased == '0) begin
      days_final = '0;
    end else if ((biased - ACC_W'(1)) > ACC_W'(DAYS_MAX)) begin
      days_final = DAYS_MAX;
    end else begin
      days_final = DAYS_W'(biased - ACC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r   <= day_of_month;
      month_r <= month_number;
      year_r  <= year_number;
      acc     <= '0;
      wd      <= WD_INIT;
      // years before the epoch only walk the counters to get the leap status
      if (year_number >= EPOCH_YEAR) begin
        yr     <= EPOCH_YEAR;
        mod4   <= EPOCH_MOD4;
        mod100 <= EPOCH_MOD100;
        mod400 <= EPOCH_MOD400;
        accum  <= 1'b1;
      end else begin
        yr     <= '0;
        mod4   <= '0;
        mod100 <= '0;
        mod400 <= '0;
        accum  <= 1'b0;
      end
    end else if (cmd.step) begin
      yr     <= yr + YEAR_W'(1);
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
      if (accum) begin
        acc <= acc + (leap ? ACC_W'(366) : ACC_W'(365));
        wd  <= wd_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      epoch_days <= days_final;
      weekday    <= wd_final;
    end
  end

endmodule

// ===== sv/dtew_ctrl.sv =====
// Controller: sequences load, year walk and final sum; owns the result valid flag.
// Depends on dtew_pkg.
module dtew_ctrl import dtew_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_YEARS;
      ST_YEARS:  if (status.years_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_YEARS:  cmd.step = !status.years_done;
      ST_FINISH: cmd.finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/date_to_epoch_days_and_weekday_top.sv =====
// Top level: date to days since 1970-01-01 and weekday (Monday = 0).
// Depends on dtew_pkg, dtew_ctrl, dtew_datapath.
//
// One request at a time. After acceptance the datapath walks one year per
// cycle from 1970 (or from year 0 for years before 1970, counting only the
// leap status) up to the requested year, then adds the months and day and
// registers the result once the output register is free. The result sits in
// an output register, so it may wait for out_ready while the next request is
// taken. Years before 1970 give the zero-based day of the year in epoch_days
// and a weekday without the years counted; otherwise epoch_days saturates
// to 0 and to its maximum, and weekday is exact.
module date_to_epoch_days_and_weekday_top import dtew_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DAY_W-1:0]   day_of_month,
  input  logic [MONTH_W-1:0] month_number,
  input  logic [YEAR_W-1:0]  year_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DAYS_W-1:0]  epoch_days,
  output logic [WD_W-1:0]    weekday
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dtew_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dtew_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .day_of_month (day_of_month),
    .month_number (month_number),
    .year_number  (year_number),
    .epoch_days   (epoch_days),
    .weekday      (weekday)
  );

endmodule

// ===== sv/dtew_checker.sv =====
// Port-level checks for the date to epoch days/weekday block, bound to the top.
// Depends on dtew_pkg.
module dtew_checker import dtew_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [DAY_W-1:0]   day_of_month,
  input logic [MONTH_W-1:0] month_number,
  input logic [YEAR_W-1:0]  year_number,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DAYS_W-1:0]  epoch_days,
  input logic [WD_W-1:0]    weekday
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(epoch_days) && $stable(weekday))
    else $error("result changed while stalled");

  a_wd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weekday <= 3'd6)
    else $error("weekday out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind date_to_epoch_days_and_weekday_top dtew_checker u_dtew_checker (.*);
